[hw/rtl/euler_yxz_to_rotation_matrix_assert.svh]
// Assertion macros shared by the rotation matrix RTL.
`ifndef EULER_YXZ_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_YXZ_TO_ROTATION_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define EYR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("eyr assertion failed");
`define EYR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("eyr implication failed");
`define EYR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("eyr next-cycle check failed");
`else
`define EYR_ASSERT(label, clk, rst_n, prop)
`define EYR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define EYR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/eyr_pkg.sv]
// Types, constants and helper functions for the rotation matrix block.
package eyr_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 14;
	localparam int VW         = FRAC_BITS + 2;
	localparam int EW         = VW + 1;
	localparam int PW         = 2 * EW + 1;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int LANES      = 6;
	localparam int PH_SH      = 32 - ANGLE_BITS;
	localparam int SIN_SH     = 30 - FRAC_BITS;

	localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
	localparam logic [31:0] QUARTER  = 32'h4000_0000;
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [30:0] SIN_A1   = 31'd1686629713;
	localparam logic [30:0] SIN_A3   = 31'd693598668;
	localparam logic [30:0] SIN_A5   = 31'd85569306;
	localparam logic [30:0] SIN_A7   = 31'd5026995;
	localparam logic [30:0] SIN_A9   = 31'd172272;

	localparam int LN_SX = 0;
	localparam int LN_CX = 1;
	localparam int LN_SY = 2;
	localparam int LN_CY = 3;
	localparam int LN_SZ = 4;
	localparam int LN_CZ = 5;

	typedef struct packed {
		logic [15:0] angle_x;
		logic [15:0] angle_y;
		logic [15:0] angle_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} out_t;

	typedef struct packed {
		logic        neg;
		logic [30:0] f;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lanes;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [31:0] to_phase(input logic [15:0] a);
		return (32'(a) & ANG_MASK) << PH_SH;
	endfunction

	function automatic lane_t classify(input logic [31:0] ph);
		lane_t r;
		r.neg = ph[31];
		r.f   = ph[30] ? (Q30_ONE - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
		return r;
	endfunction

	function automatic logic signed [VW-1:0] round_sat(input logic signed [PW-1:0] v);
		logic [PW-1:0]        mag;
		logic [PW-1:0]        r;
		logic signed [PW-1:0] s;
		logic signed [PW-1:0] one_p;
		one_p = PW'(ONE);
		mag   = v[PW-1] ? PW'(-v) : PW'(v);
		r     = (mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		s     = v[PW-1] ? -$signed(r) : $signed(r);
		if (s > one_p)
			s = one_p;
		else if (s < -one_p)
			s = -one_p;
		return VW'(s);
	endfunction
endpackage

[hw/rtl/eyr_fifo.sv]
// Short command queue between front and back.
`include "euler_yxz_to_rotation_matrix_assert.svh"
module eyr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  eyr_pkg::cmd_t       wdata,
	input  logic                pop,
	output eyr_pkg::cmd_t       rdata,
	output eyr_pkg::fifo_stat_t stat
);
	import eyr_pkg::*;

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`EYR_ASSERT(a_cnt_bound, clk, arst_n, (cnt_q <= FIFO_CW'(FIFO_DEPTH)))
	`EYR_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, (!stat.full || pop))
	`EYR_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, !stat.empty)
endmodule

[hw/rtl/eyr_front.sv]
// Front end: takes angle beats and turns them into quadrant/fraction commands.
module eyr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  eyr_pkg::in_t        src_item,
	input  eyr_pkg::fifo_stat_t stat,
	output logic                push,
	output eyr_pkg::cmd_t       cmd
);
	import eyr_pkg::*;

	in_t         in_s1;
	logic        vld_s1;
	logic [31:0] px;
	logic [31:0] py;
	logic [31:0] pz;

	assign src_stall = vld_s1 && stat.full;
	assign push      = vld_s1 && !stat.full;

	assign px = to_phase(in_s1.angle_x);
	assign py = to_phase(in_s1.angle_y);
	assign pz = to_phase(in_s1.angle_z);

	always_comb begin
		cmd.lanes[LN_SX] = classify(px);
		cmd.lanes[LN_CX] = classify(px + QUARTER);
		cmd.lanes[LN_SY] = classify(py);
		cmd.lanes[LN_CY] = classify(py + QUARTER);
		cmd.lanes[LN_SZ] = classify(pz);
		cmd.lanes[LN_CZ] = classify(pz + QUARTER);
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid)
			in_s1 <= src_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end
endmodule

[hw/rtl/eyr_sine.sv]
// Pipelined quarter-wave sine lane, Taylor series in Q30.
module eyr_sine (
	input  logic                          clk,
	input  logic                          en,
	input  eyr_pkg::lane_t                lane,
	output logic signed [eyr_pkg::VW-1:0] sine
);
	import eyr_pkg::*;

	localparam logic [32:0] RND = (33'd1 << SIN_SH) >> 1;

	logic [30:0] f_s1, f_s2, f_s3, f_s4, f_s5;
	logic        n_s1, n_s2, n_s3, n_s4, n_s5, n_s6;
	logic [30:0] f2_s1, f2_s2, f2_s3, f2_s4;
	logic [30:0] t_s2, t_s3, t_s4, t_s5;
	logic [31:0] s_s6;
	logic [32:0] r;
	logic signed [VW-1:0] v;

	always_comb begin
		r = (33'(s_s6) + RND) >> SIN_SH;
		if (r > 33'(ONE))
			v = VW'(ONE);
		else
			v = VW'(r);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1  <= lane.f;
			n_s1  <= lane.neg;
			f2_s1 <= 31'((62'(lane.f) * 62'(lane.f)) >> 30);

			f_s2  <= f_s1;
			n_s2  <= n_s1;
			f2_s2 <= f2_s1;
			t_s2  <= SIN_A7 - 31'((62'(f2_s1) * 62'(SIN_A9)) >> 30);

			f_s3  <= f_s2;
			n_s3  <= n_s2;
			f2_s3 <= f2_s2;
			t_s3  <= SIN_A5 - 31'((62'(f2_s2) * 62'(t_s2)) >> 30);

			f_s4  <= f_s3;
			n_s4  <= n_s3;
			f2_s4 <= f2_s3;
			t_s4  <= SIN_A3 - 31'((62'(f2_s3) * 62'(t_s3)) >> 30);

			f_s5  <= f_s4;
			n_s5  <= n_s4;
			t_s5  <= SIN_A1 - 31'((62'(f2_s4) * 62'(t_s4)) >> 30);

			n_s6  <= n_s5;
			s_s6  <= 32'((62'(f_s5) * 62'(t_s5)) >> 30);

			sine  <= n_s6 ? -v : v;
		end
	end
endmodule

[hw/rtl/eyr_back.sv]
// Back end: six sine lanes, inner products, matrix elements, output register.
`include "euler_yxz_to_rotation_matrix_assert.svh"
module eyr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  eyr_pkg::cmd_t       cmd,
	input  eyr_pkg::fifo_stat_t stat,
	output logic                pop,
	output logic                dst_valid,
	input  logic                dst_stall,
	output eyr_pkg::out_t       dst_item
);
	import eyr_pkg::*;

	localparam int NST = 9;

	logic [NST-1:0]       vld_q;
	logic                 en;
	logic signed [VW-1:0] sn [LANES];
	logic signed [VW-1:0] sx_s8, cx_s8, sy_s8, cy_s8, sz_s8, cz_s8;
	logic signed [VW-1:0] sxsy_s8, sxcy_s8;

	assign en        = !(vld_q[NST-1] && dst_stall);
	assign pop       = en && !stat.empty;
	assign dst_valid = vld_q[NST-1];

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		eyr_sine u_sine (
			.clk  (clk),
			.en   (en),
			.lane (cmd.lanes[i]),
			.sine (sn[i])
		);
	end

	function automatic logic signed [PW-1:0] mul(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

	function automatic logic signed [15:0] ow(input logic signed [VW-1:0] v);
		return 16'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s8   <= sn[LN_SX];
			cx_s8   <= sn[LN_CX];
			sy_s8   <= sn[LN_SY];
			cy_s8   <= sn[LN_CY];
			sz_s8   <= sn[LN_SZ];
			cz_s8   <= sn[LN_CZ];
			sxsy_s8 <= round_sat(mul(sn[LN_SX], sn[LN_SY]));
			sxcy_s8 <= round_sat(mul(sn[LN_SX], sn[LN_CY]));

			dst_item.m00 <= ow(round_sat(mul(cz_s8, cy_s8) - mul(sz_s8, sxsy_s8)));
			dst_item.m01 <= ow(round_sat(-mul(sz_s8, cx_s8)));
			dst_item.m02 <= ow(round_sat(mul(cz_s8, sy_s8) + mul(sz_s8, sxcy_s8)));
			dst_item.m10 <= ow(round_sat(mul(sz_s8, cy_s8) + mul(cz_s8, sxsy_s8)));
			dst_item.m11 <= ow(round_sat(mul(cz_s8, cx_s8)));
			dst_item.m12 <= ow(round_sat(mul(sz_s8, sy_s8) - mul(cz_s8, sxcy_s8)));
			dst_item.m20 <= ow(round_sat(-mul(cx_s8, sy_s8)));
			dst_item.m21 <= ow(sx_s8);
			dst_item.m22 <= ow(round_sat(mul(cx_s8, cy_s8)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], !stat.empty};
		end
	end

	`EYR_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, (dst_valid && dst_stall), dst_valid)
	`EYR_ASSERT_NEXT(a_pop_enters, clk, arst_n, pop, vld_q[0])
	`EYR_ASSERT_IMPLY(a_inner_range, clk, arst_n, vld_q[NST-2],
		((sxsy_s8 <= VW'(ONE)) && (sxsy_s8 >= -VW'(ONE))))
endmodule

[hw/rtl/euler_yxz_to_rotation_matrix.sv]
// Euler angle (Y, X, Z order) to 3x3 rotation matrix, top level.
//
// Input channel src_*: one beat carries angle_x, angle_y, angle_z as binary
// angles (65536 = one turn). Output channel dst_*: one beat carries the nine
// elements m00..m22 of R = Rz * Rx * Ry in signed Q1.14, clamped to +/-1.0.
// Every input beat gives exactly one output beat, in order.
// Stages from input acceptance to output valid: front register, command
// queue, seven-stage sine lanes, inner product stage, element stage with
// output register.
// Throughput: one beat per cycle when neither side stalls; the six sine lanes
// are fully pipelined. When dst_stall is high with dst_valid set, the whole
// back pipeline holds; the four-entry command queue keeps taking beats until
// full, then src_stall rises. Reset (arst_n low) empties the queue and clears
// all valids; no matrix state is kept between beats.
module euler_yxz_to_rotation_matrix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	input  eyr_pkg::in_t  src_item,
	output logic          dst_valid,
	input  logic          dst_stall,
	output eyr_pkg::out_t dst_item
);
	import eyr_pkg::*;

	cmd_t       cmd_w;
	cmd_t       head;
	fifo_stat_t stat;
	logic       push;
	logic       pop;

	eyr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.stat      (stat),
		.push      (push),
		.cmd       (cmd_w)
	);

	eyr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_w),
		.pop    (pop),
		.rdata  (head),
		.stat   (stat)
	);

	eyr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.stat      (stat),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);
endmodule

[test/euler_yxz_to_rotation_matrix_tb.sv]
// Testbench for the Euler YXZ rotation matrix block: a predicted result for every beat.
module euler_yxz_to_rotation_matrix_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import eyr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS = 1300;

	typedef struct {
		in_t  angles;
		bit   typed;
		out_t matrix;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  src_valid;
	logic  src_stall;
	in_t   src_item;
	logic  dst_valid;
	logic  dst_stall;
	out_t  dst_item;

	out_t  matrix_queue[$];
	int    failures;
	int    cycles;
	int    src_idle_pct;
	int    dst_idle_pct;
	row_t  rows[$];

	euler_yxz_to_rotation_matrix DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item(dst_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp_unit(longint v);
		longint one;
		one = longint'(1) << FRAC_BITS;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	function automatic longint round_half_away(longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint fixed_sine(bit [31:0] ph);
		bit [63:0] f, f2, t, s;
		longint v;
		f = {34'b0, ph[29:0]};
		if (ph[30]) f = 64'h4000_0000 - f;
		f2 = (f * f) >> 30;
		t = 64'd5026995 - ((f2 * 64'd172272) >> 30);
		t = 64'd85569306 - ((f2 * t) >> 30);
		t = 64'd693598668 - ((f2 * t) >> 30);
		t = 64'd1686629713 - ((f2 * t) >> 30);
		s = (f * t) >> 30;
		s = (s + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
		v = clamp_unit(longint'(s));
		return ph[31] ? -v : v;
	endfunction

	function automatic longint elem(longint a, longint b, longint c, longint d);
		return clamp_unit(round_half_away(a * b + c * d));
	endfunction

	function automatic out_t rotation_matrix(in_t a);
		bit [31:0] px, py, pz;
		longint sx, cx, sy, cy, sz, cz, sxsy, sxcy;
		out_t m;
		px = {a.angle_x, 16'b0};
		py = {a.angle_y, 16'b0};
		pz = {a.angle_z, 16'b0};
		sx = fixed_sine(px); cx = fixed_sine(px + 32'h4000_0000);
		sy = fixed_sine(py); cy = fixed_sine(py + 32'h4000_0000);
		sz = fixed_sine(pz); cz = fixed_sine(pz + 32'h4000_0000);
		sxsy = elem(sx, sy, 0, 0);
		sxcy = elem(sx, cy, 0, 0);
		m.m00 = 16'(elem(cz, cy, -sz, sxsy));
		m.m01 = 16'(elem(-sz, cx, 0, 0));
		m.m02 = 16'(elem(cz, sy, sz, sxcy));
		m.m10 = 16'(elem(sz, cy, cz, sxsy));
		m.m11 = 16'(elem(cz, cx, 0, 0));
		m.m12 = 16'(elem(sz, sy, -cz, sxcy));
		m.m20 = 16'(elem(-cx, sy, 0, 0));
		m.m21 = 16'(sx);
		m.m22 = 16'(elem(cx, cy, 0, 0));
		return m;
	endfunction

	task automatic send_beat(in_t a);
		while (($urandom_range(99) < src_idle_pct)) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= a;
		matrix_queue.push_back(rotation_matrix(a));
		@(posedge clk);
		while (src_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_row(bit [15:0] x, bit [15:0] y, bit [15:0] z);
		row_t r;
		r.angles = '{x, y, z};
		r.typed = 1'b0;
		rows.push_back(r);
	endtask

	task automatic add_typed(bit [15:0] x, bit [15:0] y, bit [15:0] z, out_t m);
		row_t r;
		r.angles = '{x, y, z};
		r.typed = 1'b1;
		r.matrix = m;
		rows.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (matrix_queue.size() == 0) begin
				$error("unexpected matrix beat %h", dst_item);
				failures++;
			end else begin
				out_t e;
				e = matrix_queue.pop_front();
				if (dst_item.m00 !== e.m00) begin
					$error("m00 exp %0d got %0d", e.m00, dst_item.m00); failures++;
				end
				if (dst_item.m01 !== e.m01) begin
					$error("m01 exp %0d got %0d", e.m01, dst_item.m01); failures++;
				end
				if (dst_item.m02 !== e.m02) begin
					$error("m02 exp %0d got %0d", e.m02, dst_item.m02); failures++;
				end
				if (dst_item.m10 !== e.m10) begin
					$error("m10 exp %0d got %0d", e.m10, dst_item.m10); failures++;
				end
				if (dst_item.m11 !== e.m11) begin
					$error("m11 exp %0d got %0d", e.m11, dst_item.m11); failures++;
				end
				if (dst_item.m12 !== e.m12) begin
					$error("m12 exp %0d got %0d", e.m12, dst_item.m12); failures++;
				end
				if (dst_item.m20 !== e.m20) begin
					$error("m20 exp %0d got %0d", e.m20, dst_item.m20); failures++;
				end
				if (dst_item.m21 !== e.m21) begin
					$error("m21 exp %0d got %0d", e.m21, dst_item.m21); failures++;
				end
				if (dst_item.m22 !== e.m22) begin
					$error("m22 exp %0d got %0d", e.m22, dst_item.m22); failures++;
				end
			end
		end
	end

	always @(negedge clk) begin
		dst_stall <= ($urandom_range(99) < dst_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic in_t random_angles();
		in_t a;
		int k;
		a.angle_x = 16'($urandom);
		a.angle_y = 16'($urandom);
		a.angle_z = 16'($urandom);
		k = $urandom_range(3);
		// lean on quadrant boundaries where the sine is mirrored or clamped
		if (k == 0)
			a.angle_x = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(4)) - 16'd2;
		if (k == 1)
			a.angle_y = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(4)) - 16'd2;
		if (k == 2)
			a.angle_z = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(4)) - 16'd2;
		return a;
	endfunction

	initial begin
		int n;
		failures = 0;
		cycles = 0;
		src_valid = 1'b0;
		src_item = '0;
		dst_stall = 1'b0;
		src_idle_pct = 16;
		dst_idle_pct = 77;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_typed(16'h0000, 16'h0000, 16'h0000,
			'{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384});
		add_typed(16'h4000, 16'h0000, 16'h0000,
			'{16'sd16384, 0, 0, 0, 0, -16'sd16384, 0, 16'sd16384, 0});
		add_typed(16'h0000, 16'h4000, 16'h0000,
			'{0, 0, 16'sd16384, 0, 16'sd16384, 0, -16'sd16384, 0, 0});
		add_typed(16'h0000, 16'h0000, 16'h4000,
			'{0, -16'sd16384, 0, 16'sd16384, 0, 0, 0, 0, 16'sd16384});
		add_typed(16'h8000, 16'h8000, 16'h8000,
			'{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384});
		add_row(16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_row(16'hC000, 16'hC000, 16'hC000);
		add_row(16'h3FFF, 16'h4001, 16'h7FFF);
		add_row(16'h8001, 16'hBFFF, 16'hC001);
		add_row(16'h0001, 16'h0002, 16'h0004);
		add_row(16'h2000, 16'h2000, 16'h2000);
		add_row(16'hAAAA, 16'h5555, 16'hAAAA);
		add_row(16'h5555, 16'hAAAA, 16'h5555);
		add_row(16'h1234, 16'hFEDC, 16'h8000);

		foreach (rows[i]) begin
			if (rows[i].typed && rows[i].matrix !== rotation_matrix(rows[i].angles)) begin
				$error("table row %0d disagrees with predictor", i);
				failures++;
			end
			send_beat(rows[i].angles);
		end

		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n == RANDOM_BEATS / 3) begin
				src_idle_pct = 77;
				dst_idle_pct = 16;
			end
			if (n == 2 * RANDOM_BEATS / 3) begin
				// hold off until the pipeline drains
				src_valid <= 1'b0;
				@(negedge clk);
				while (matrix_queue.size() != 0) @(negedge clk);
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			send_beat(random_angles());
		end

		src_valid <= 1'b0;
		@(negedge clk);
		while (matrix_queue.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
